// File: hdl/tlb_lru_lookup_insert_top_macros.svh
`ifndef TLB_LRU_LOOKUP_INSERT_TOP_MACROS_SVH
`define TLB_LRU_LOOKUP_INSERT_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low
`define TLB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define TLB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/tlb_pkg.sv
package tlb_pkg;

	localparam int ENTRIES    = 16;
	localparam int PAGE_BITS  = 20;
	localparam int FRAME_BITS = 20;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int AGE_W      = $clog2(ENTRIES);
	localparam int CFG_W      = 5;
	localparam int CFG_RESET  = 16;

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	typedef enum logic [1:0] {
		UPD_NONE,
		UPD_TOUCH,
		UPD_FILL
	} upd_op_t;

	typedef struct packed {
		upd_op_t               op;
		logic [IDX_W-1:0]      idx;
		logic                  wr_page;
		logic                  wr_frame;
		logic [PAGE_BITS-1:0]  page;
		logic [FRAME_BITS-1:0] frame;
	} upd_cmd_t;

	typedef struct packed {
		logic                  valid;
		logic [PAGE_BITS-1:0]  page;
		logic [FRAME_BITS-1:0] frame;
		logic [AGE_W-1:0]      age;
	} entry_t;

	typedef struct packed {
		logic                  hit;
		logic [FRAME_BITS-1:0] frame;
		logic                  evicted;
		logic [PAGE_BITS-1:0]  evicted_page;
	} result_t;

	// index of the last usable slot: 0 acts as 1, anything above ENTRIES as ENTRIES
	function automatic logic [IDX_W-1:0] last_slot(input logic [CFG_W-1:0] cfg);
		int unsigned c;
		int unsigned r;
		c = int'(cfg);
		if (c == 0) begin
			r = 0;
		end else if (c > ENTRIES) begin
			r = ENTRIES - 1;
		end else begin
			r = c - 1;
		end
		return r[IDX_W-1:0];
	endfunction

endpackage

// File: hdl/tlb_store.sv
module tlb_store
	import tlb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_idx,
	output entry_t           rd_entry,
	input  upd_cmd_t         upd
);

	logic                  valid_q [ENTRIES];
	logic [AGE_W-1:0]      age_q   [ENTRIES];
	logic [PAGE_BITS-1:0]  page_q  [ENTRIES];
	logic [FRAME_BITS-1:0] frame_q [ENTRIES];
	logic [AGE_W-1:0]      touch_age;

	assign rd_entry.valid = valid_q[rd_idx];
	assign rd_entry.page  = page_q[rd_idx];
	assign rd_entry.frame = frame_q[rd_idx];
	assign rd_entry.age   = age_q[rd_idx];

	assign touch_age = age_q[upd.idx];

	// recency ranks: valid slots always hold 0..count-1 exactly once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				age_q[i]   <= '0;
			end
		end else begin
			unique case (upd.op)
				UPD_TOUCH: begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid_q[i] && IDX_W'(i) != upd.idx && age_q[i] < touch_age) begin
							age_q[i] <= age_q[i] + AGE_W'(1);
						end
					end
					age_q[upd.idx] <= '0;
				end
				UPD_FILL: begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid_q[i]) begin
							age_q[i] <= age_q[i] + AGE_W'(1);
						end
					end
					valid_q[upd.idx] <= 1'b1;
					age_q[upd.idx]   <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (upd.op == UPD_FILL || (upd.op == UPD_TOUCH && upd.wr_page)) begin
			page_q[upd.idx] <= upd.page;
		end
		if (upd.op == UPD_FILL || (upd.op == UPD_TOUCH && upd.wr_frame)) begin
			frame_q[upd.idx] <= upd.frame;
		end
	end

endmodule

// File: hdl/tlb_ctrl.sv
`include "tlb_lru_lookup_insert_top_macros.svh"

module tlb_ctrl
	import tlb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_kind,
	input  logic [PAGE_BITS-1:0]  in_page,
	input  logic [FRAME_BITS-1:0] in_frame,
	input  logic [IDX_W-1:0]      lim_last,
	output logic [IDX_W-1:0]      rd_idx,
	input  entry_t                rd_entry,
	output upd_cmd_t              upd,
	output logic                  res_valid,
	input  logic                  res_ready,
	output result_t               res
);

	state_t state_q, state_d;

	logic                  kind_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [IDX_W-1:0]      lim_q;
	logic [IDX_W-1:0]      idx_q;

	logic                  match_q;
	logic [IDX_W-1:0]      match_idx_q;
	logic [FRAME_BITS-1:0] match_frame_q;
	logic                  free_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic                  old_q;
	logic [IDX_W-1:0]      old_idx_q;
	logic [AGE_W-1:0]      old_age_q;
	logic [PAGE_BITS-1:0]  old_page_q;

	logic accept;
	logic scan_last;
	logic is_match;
	logic is_older;
	logic do_evict;

	assign accept    = in_valid && in_ready;
	assign scan_last = (idx_q == lim_q);
	assign rd_idx    = idx_q;

	// the shared compare unit: one slot per cycle
	assign is_match = rd_entry.valid && !match_q && (rd_entry.page == page_q);
	assign is_older = rd_entry.valid && (!old_q || rd_entry.age > old_age_q);

	assign do_evict = (kind_q == KIND_INSERT) && !match_q && !free_q && old_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SCAN;
			ST_SCAN:   if (scan_last) state_d = ST_UPDATE;
			ST_UPDATE: if (res_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		res_valid = (state_q == ST_UPDATE) && res_ready;

		res.hit          = match_q;
		res.frame        = (kind_q == KIND_LOOKUP && match_q) ? match_frame_q : '0;
		res.evicted      = do_evict;
		res.evicted_page = do_evict ? old_page_q : '0;

		upd.op       = UPD_NONE;
		upd.idx      = match_idx_q;
		upd.wr_page  = 1'b0;
		upd.wr_frame = 1'b0;
		upd.page     = page_q;
		upd.frame    = frame_q;
		if (res_valid) begin
			priority if (match_q) begin
				upd.op       = UPD_TOUCH;
				upd.wr_frame = (kind_q == KIND_INSERT);
			end else if (kind_q == KIND_LOOKUP) begin
				upd.op = UPD_NONE;
			end else if (free_q) begin
				upd.op  = UPD_FILL;
				upd.idx = free_idx_q;
			end else if (old_q) begin
				// evict in place, then make it most recent
				upd.op       = UPD_TOUCH;
				upd.idx      = old_idx_q;
				upd.wr_page  = 1'b1;
				upd.wr_frame = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			old_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q   <= '0;
				match_q <= 1'b0;
				free_q  <= 1'b0;
				old_q   <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (!scan_last) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (is_match) begin
					match_q <= 1'b1;
				end
				if (is_older) begin
					old_q <= 1'b1;
				end
				if (!rd_entry.valid && !free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= in_kind;
			page_q  <= in_page;
			frame_q <= in_frame;
			lim_q   <= lim_last;
		end else if (state_q == ST_SCAN) begin
			if (is_match) begin
				match_idx_q   <= idx_q;
				match_frame_q <= rd_entry.frame;
			end
			if (is_older) begin
				old_idx_q  <= idx_q;
				old_age_q  <= rd_entry.age;
				old_page_q <= rd_entry.page;
			end
			if (!rd_entry.valid && !free_q) begin
				free_idx_q <= idx_q;
			end
		end
	end

	`TLB_ASSERT_NEXT(a_accept_scans, accept, state_q == ST_SCAN, "item accepted but no scan")
	`TLB_ASSERT_NOW(a_idx_in_range, state_q == ST_SCAN, idx_q <= lim_q, "scan past last slot")
	`TLB_ASSERT_NOW(a_hit_xor_evict, res_valid, !(res.hit && res.evicted),
		"hit and eviction together")
	`TLB_ASSERT_NOW(a_insert_placed, res_valid && kind_q == KIND_INSERT,
		match_q || free_q || old_q, "insert found no slot")

endmodule

// File: hdl/tlb_lru_lookup_insert_top.sv
// Channel   Signals                      Fields (low bit first)
// s_*       s_tvalid s_tready            tuser: kind; tdata: page_number, frame_in
// m_*       m_tvalid m_tready            tuser: hit, evicted; tdata: frame_out, evicted_page
// cfg_*     cfg_wr_en cfg_wr_data        entries_in_use (5 bits, reset 16)
//
// Each item runs accept, then a scan of n slots, n the usable entry count (1..16), one
// slot per cycle through the single page/age comparator, then an update.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register; the next item is taken while it waits,
// and that item stalls in its update cycle until the register drains.
// arst_n clears all valid bits and ages at once; no clearing pass.
module tlb_lru_lookup_insert_top
	import tlb_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic                            s_tuser,   // kind
	input  logic [PAGE_BITS+FRAME_BITS-1:0] s_tdata,   // page_number, frame_in
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [1:0]                      m_tuser,   // hit, evicted
	output logic [FRAME_BITS+PAGE_BITS-1:0] m_tdata,   // frame_out, evicted_page
	input  logic                            cfg_wr_en,
	input  logic [CFG_W-1:0]                cfg_wr_data
);

	logic [CFG_W-1:0] cfg_q;
	logic             m_valid_q;
	result_t          res_q;

	logic             res_valid;
	logic             res_ready;
	result_t          res;
	logic [IDX_W-1:0] rd_idx;
	entry_t           rd_entry;
	upd_cmd_t         upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_W'(CFG_RESET);
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = {res_q.evicted, res_q.hit};
	assign m_tdata  = {res_q.evicted_page, res_q.frame};

	tlb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_page   (s_tdata[PAGE_BITS-1:0]),
		.in_frame  (s_tdata[PAGE_BITS+FRAME_BITS-1:PAGE_BITS]),
		.lim_last  (last_slot(cfg_q)),
		.rd_idx    (rd_idx),
		.rd_entry  (rd_entry),
		.upd       (upd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	tlb_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (rd_idx),
		.rd_entry (rd_entry),
		.upd      (upd)
	);

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench
	import tlb_pkg::*;
();

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 88;
	localparam int POOL_SIZE    = 20;
	localparam int SETTLE_TICKS = 20;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic                            s_tuser = KIND_LOOKUP;
	logic [PAGE_BITS+FRAME_BITS-1:0] s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [1:0]                      m_tuser;
	logic [FRAME_BITS+PAGE_BITS-1:0] m_tdata;
	logic                            cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]                cfg_wr_data = '0;

	// tracks translation state and queues the result each accepted item should give
	class translation_tracker;
		logic [CFG_W-1:0]      entry_count;
		bit                    slot_valid [ENTRIES];
		logic [PAGE_BITS-1:0]  slot_page  [ENTRIES];
		logic [FRAME_BITS-1:0] slot_frame [ENTRIES];
		int                    slot_rank  [ENTRIES];
		result_t               pending_results[$];
		int                    mismatches;

		function new();
			entry_count = CFG_W'(CFG_RESET);
			mismatches = 0;
			for (int i = 0; i < ENTRIES; i++) begin
				slot_valid[i] = 1'b0;
				slot_page[i] = '0;
				slot_frame[i] = '0;
				slot_rank[i] = 0;
			end
		endfunction

		function void set_entry_count(logic [CFG_W-1:0] value);
			entry_count = value;
		endfunction

		function int usable_slots();
			if (entry_count == 0)
				return 1;
			if (int'(entry_count) > ENTRIES)
				return ENTRIES;
			return int'(entry_count);
		endfunction

		// make slot most recent; younger valid slots age by one
		function void make_recent(int slot);
			int r;
			r = slot_rank[slot];
			for (int i = 0; i < ENTRIES; i++)
				if (slot_valid[i] && i != slot && slot_rank[i] < r)
					slot_rank[i]++;
			slot_rank[slot] = 0;
		endfunction

		function void accept_request(logic kind, logic [PAGE_BITS-1:0] page,
				logic [FRAME_BITS-1:0] frame);
			int      lim;
			int      match;
			int      free_slot;
			int      oldest;
			result_t res;
			lim = usable_slots();
			match = -1;
			free_slot = -1;
			oldest = -1;
			res = '0;
			for (int i = 0; i < lim; i++) begin
				if (slot_valid[i]) begin
					if (match < 0 && slot_page[i] == page)
						match = i;
					if (oldest < 0 || slot_rank[i] > slot_rank[oldest])
						oldest = i;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (kind == KIND_LOOKUP) begin
				if (match >= 0) begin
					res.hit = 1'b1;
					res.frame = slot_frame[match];
					make_recent(match);
				end
			end else if (match >= 0) begin
				// insert of a page already held: update in place
				res.hit = 1'b1;
				slot_frame[match] = frame;
				make_recent(match);
			end else if (free_slot >= 0) begin
				for (int i = 0; i < ENTRIES; i++)
					if (slot_valid[i])
						slot_rank[i]++;
				slot_valid[free_slot] = 1'b1;
				slot_page[free_slot] = page;
				slot_frame[free_slot] = frame;
				slot_rank[free_slot] = 0;
			end else if (oldest >= 0) begin
				res.evicted = 1'b1;
				res.evicted_page = slot_page[oldest];
				slot_page[oldest] = page;
				slot_frame[oldest] = frame;
				make_recent(oldest);
			end
			pending_results = {pending_results, res};
		endfunction

		task flag_mismatch(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		task check_response(logic hit, logic [FRAME_BITS-1:0] frame, logic evicted,
				logic [PAGE_BITS-1:0] evicted_page);
			result_t want;
			if (pending_results.size() == 0) begin
				flag_mismatch("result with no item outstanding");
				return;
			end
			want = pending_results[0];
			pending_results.delete(0);
			if (hit !== want.hit)
				flag_mismatch($sformatf("hit %b, want %b", hit, want.hit));
			if (frame !== want.frame)
				flag_mismatch($sformatf("frame_out %h, want %h", frame, want.frame));
			if (evicted !== want.evicted)
				flag_mismatch($sformatf("evicted %b, want %b", evicted, want.evicted));
			if (evicted_page !== want.evicted_page)
				flag_mismatch($sformatf("evicted_page %h, want %h",
					evicted_page, want.evicted_page));
		endtask
	endclass

	translation_tracker tracker = new();

	int                   idle_mode = 0;
	int                   cycle_count = 0;
	logic [PAGE_BITS-1:0] page_pool [POOL_SIZE];
	logic [CFG_W-1:0]     phase_counts [8] = '{5'd31, 5'd0, 5'd4, 5'd16, 5'd2, 5'd17, 5'd9, 5'd12};

	tlb_lru_lookup_insert_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tuser     (s_tuser),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tuser     (m_tuser),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic int stall_pct(bit sender);
		unique case (idle_mode)
			1: return sender ? 87 : 0;
			2: return sender ? 0 : 87;
			3: return 38;
			default: return 0;
		endcase
	endfunction

	// result side: sample before re-rolling tready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_response(m_tuser[0], m_tdata[FRAME_BITS-1:0], m_tuser[1],
				m_tdata[FRAME_BITS+PAGE_BITS-1:FRAME_BITS]);
		if (arst_n)
			m_tready <= ($urandom_range(99) >= stall_pct(1'b0));
	end

	task send_item(logic kind, logic [PAGE_BITS-1:0] page, logic [FRAME_BITS-1:0] frame);
		while ($urandom_range(99) < stall_pct(1'b1)) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {frame, page};
		do
			@(posedge clk);
		while (!s_tready);
		tracker.accept_request(kind, page, frame);
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// only written with the block idle
	task write_entry_count(logic [CFG_W-1:0] value);
		drain();
		repeat (SETTLE_TICKS) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_entry_count(value);
	endtask

	initial begin
		int                    pool_n;
		logic [PAGE_BITS-1:0]  page;
		for (int i = 0; i < POOL_SIZE; i++)
			page_pool[i] = PAGE_BITS'($urandom);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: misses on empty store, extremes, in-place update
		send_item(KIND_LOOKUP, '0, '1);
		send_item(KIND_LOOKUP, '1, '0);
		send_item(KIND_INSERT, '0, '1);
		send_item(KIND_INSERT, '1, '0);
		send_item(KIND_LOOKUP, '0, '0);
		send_item(KIND_LOOKUP, '1, '1);
		send_item(KIND_INSERT, '0, 20'h5a5a5);
		send_item(KIND_LOOKUP, '0, '0);
		// one usable slot: slot 1 is hidden, insert evicts page 0
		write_entry_count(5'd1);
		send_item(KIND_LOOKUP, '1, '0);
		send_item(KIND_INSERT, '1, 20'ha5a5a);
		send_item(KIND_INSERT, 20'h12345, 20'h0f0f0);
		send_item(KIND_INSERT, '1, 20'h33333);
		// hidden slot visible again: duplicate page, lowest slot wins
		write_entry_count(5'd16);
		send_item(KIND_LOOKUP, '1, '0);
		send_item(KIND_INSERT, '1, 20'h77777);
		send_item(KIND_LOOKUP, '1, '0);
		// two slots: LRU order decides the victim
		write_entry_count(5'd2);
		send_item(KIND_INSERT, 20'h00001, 20'h00011);
		send_item(KIND_LOOKUP, '1, '0);
		send_item(KIND_INSERT, 20'h00002, 20'h00022);
		send_item(KIND_LOOKUP, 20'h00001, '0);
		send_item(KIND_INSERT, 20'h00003, 20'h00033);
		send_item(KIND_LOOKUP, 20'h00002, '0);

		for (int ph = 0; ph < 8; ph++) begin
			write_entry_count(phase_counts[ph]);
			idle_mode = ph % 4;
			pool_n = tracker.usable_slots() + 3;
			if (pool_n > POOL_SIZE)
				pool_n = POOL_SIZE;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(9) == 0)
					page = PAGE_BITS'($urandom);
				else
					page = page_pool[$urandom_range(pool_n - 1)];
				send_item(logic'($urandom_range(1)), page, FRAME_BITS'($urandom));
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (tracker.pending_results.size() != 0)
			tracker.flag_mismatch("results still outstanding at end");
		if (tracker.mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
